/* rtl/vadpcm_frame_decoder_core_assert.svh */
// Assertion macros shared by the frame decoder modules.
// Expects clk and rst_n in the scope of each use.
`ifndef VADPCM_FRAME_DECODER_CORE_ASSERT_SVH
`define VADPCM_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, skipped while in reset
`define VFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfd assertion failed");

// Next-cycle implication, skipped while in reset
`define VFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfd assertion failed");

`endif

/* rtl/vfd_pkg.sv */
// Shared types and constants of the VADPCM frame decoder.
// No dependencies; used by the controller, datapath and top level.
package vfd_pkg;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRED_COUNT = 2'd0;
  localparam logic [1:0] CFG_ORDER      = 2'd1;
  localparam logic [1:0] CFG_ENABLE     = 2'd2;

  // Operand selects for one multiply-accumulate term
  localparam logic [1:0] OP_HIST1 = 2'd0;
  localparam logic [1:0] OP_HIST0 = 2'd1;
  localparam logic [1:0] OP_SMP   = 2'd2;

  // Widths
  localparam int BASE_W = 11;  // pred*order*8 reaches 1800
  localparam int ACC_W  = 38;  // nine 32-bit products plus scaled nibble
  localparam int RAW_W  = 19;  // 4-bit nibble shifted by up to 15
  localparam int FRAC   = 11;

  typedef struct packed {
    logic       capture;   // take the accepted word
    logic       reduce;    // one modulo step on the address base
    logic       ram_we;    // store the loaded coefficient
    logic       issue;     // start one product term
    logic [3:0] off;       // coefficient offset from the predictor base
    logic [1:0] opsel;     // operand of the term
    logic [2:0] opj;       // earlier sample of this half
    logic       fin;       // finish the sample and load the output register
    logic       hist_upd;  // half done: refresh the history
    logic [3:0] idx;       // sample position within the frame
  } vfd_cmd_t;

  typedef struct packed {
    logic red_ge;    // base still at or above the depth
    logic out_free;  // output register can take a sample
    logic is_load;   // captured word is a coefficient load
  } vfd_sts_t;

endpackage

/* rtl/vfd_if.sv */
// Valid/ready channel interfaces of the frame decoder.
// No dependencies.
interface vfd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         frame_header;
  logic [31:0]        frame_first_half;
  logic [31:0]        frame_second_half;
  logic               start_voice;

  modport source (output valid, req_type, coef_index, coef_value, frame_header,
                  frame_first_half, frame_second_half, start_voice, input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, frame_header,
                  frame_first_half, frame_second_half, start_voice, output ready);
endinterface

interface vfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [3:0]         sample_index;
  logic               last;

  modport source (output valid, sample, sample_index, last, input ready);
  modport sink   (input valid, sample, sample_index, last, output ready);
endinterface

/* rtl/vfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/vfd_ctrl.sv */
// Controller of the frame decoder: sequences loads, address reduction,
// product terms and sample completion. Depends on vfd_pkg and the assert header.
`include "vadpcm_frame_decoder_core_assert.svh"

module vfd_ctrl
  import vfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cb_enable,
  input  vfd_sts_t sts,
  output vfd_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_ISSUE  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       half_r, half_nxt;
  logic [2:0] i_r, i_nxt;
  logic [3:0] k_r, k_nxt;
  logic       drain_r, drain_nxt;
  logic [3:0] k_last;

  assign in_ready = (state_r == ST_IDLE);
  assign k_last   = 4'(i_r) + 4'd1;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    half_nxt  = half_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.idx   = {half_r, i_r};
    cmd.opj   = 3'(k_r - 4'd2);
    unique case (k_r)
      4'd0: begin
        cmd.off   = {1'b0, i_r};
        cmd.opsel = OP_HIST1;
      end
      4'd1: begin
        cmd.off   = {1'b1, i_r};
        cmd.opsel = OP_HIST0;
      end
      default: begin
        cmd.off   = 4'(5'd9 + 5'(i_r) - 5'(k_r));
        cmd.opsel = OP_SMP;
      end
    endcase
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (!sts.red_ge) begin
          if (sts.is_load) begin
            cmd.ram_we = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            half_nxt  = 1'b0;
            i_nxt     = 3'd0;
            k_nxt     = 4'd0;
            state_nxt = cb_enable ? ST_ISSUE : ST_FIN;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (k_r == k_last) begin
          k_nxt     = 4'd0;
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin      = 1'b1;
          cmd.hist_upd = (i_r == 3'd7);
          k_nxt        = 4'd0;
          if (i_r == 3'd7 && half_r) begin
            state_nxt = ST_IDLE;
          end else begin
            {half_nxt, i_nxt} = {half_r, i_r} + 4'd1;
            state_nxt         = cb_enable ? ST_ISSUE : ST_FIN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      half_r  <= 1'b0;
      i_r     <= 3'd0;
      k_r     <= 4'd0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      half_r  <= half_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

  `VFD_ASSERT_IMP(a_term_bound, state_r == ST_ISSUE, k_r <= k_last)
  `VFD_ASSERT_NXT(a_fin_hold, (state_r == ST_FIN) && !sts.out_free, state_r == ST_FIN)

endmodule

/* rtl/vfd_datapath.sv */
// Datapath of the frame decoder: codebook RAM, address reduction, MAC
// pipeline, history, saturation and output register. Depends on vfd_pkg,
// vfd_ram, vfd_out_if and the assert header.
`include "vadpcm_frame_decoder_core_assert.svh"

module vfd_datapath
  import vfd_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_type,
  input  logic [7:0]         coef_index,
  input  logic signed [15:0] coef_value,
  input  logic [7:0]         frame_header,
  input  logic [31:0]        frame_first_half,
  input  logic [31:0]        frame_second_half,
  input  logic               start_voice,
  input  logic [4:0]         pred_count,
  input  logic [3:0]         cb_order,
  input  vfd_cmd_t           cmd,
  output vfd_sts_t           sts,
  vfd_out_if.source          out_ch
);

  localparam int AW = $clog2(CODEBOOK_DEPTH);
  localparam logic [BASE_W:0] DEPTH_L = (BASE_W + 1)'(CODEBOOK_DEPTH);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  logic               req_type_r;
  logic signed [15:0] coef_value_r;
  logic [3:0]         scale_r;
  logic [31:0]        first_r;
  logic [31:0]        second_r;
  logic [BASE_W-1:0]  red_r;
  logic signed [15:0] hist0_r;
  logic signed [15:0] hist1_r;
  logic signed [15:0] smp_r [8];

  logic [3:0]         pred;
  logic [3:0]         order;
  logic [7:0]         pred_x_order;
  logic               red_ge;
  logic [BASE_W:0]    addr_sum;
  logic [BASE_W:0]    addr_mod;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        rd_data;
  logic signed [15:0] opnd;

  logic               vld_b_r;
  logic signed [15:0] opnd_b_r;
  logic               vld_c_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [31:0]             word;
  logic [3:0]              nib;
  logic signed [RAW_W-1:0] raw;
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] shifted;
  logic signed [15:0]      fin_sample;

  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic [3:0]         out_idx_r;

  // Clamp predictor index and fix order zero
  always_comb begin
    pred = frame_header[3:0];
    if (pred_count != 5'd0 && {1'b0, pred} >= pred_count) begin
      pred = 4'(pred_count - 5'd1);
    end
    order = (cb_order == 4'd0) ? 4'd2 : cb_order;
  end
  assign pred_x_order = pred * order;

  // Capture the accepted word; reduce the base modulo the depth
  assign red_ge = {1'b0, red_r} >= DEPTH_L;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r   <= req_type;
      coef_value_r <= coef_value;
      scale_r      <= frame_header[7:4];
      first_r      <= frame_first_half;
      second_r     <= frame_second_half;
      red_r        <= (req_type == REQ_LOAD) ? BASE_W'(coef_index)
                                             : BASE_W'({pred_x_order, 3'b000});
    end else if (cmd.reduce && red_ge) begin
      red_r <= BASE_W'({1'b0, red_r} - DEPTH_L);
    end
  end

  // Coefficient address: base plus offset, wrapped once
  always_comb begin
    addr_sum = {1'b0, red_r} + (BASE_W + 1)'(cmd.off);
    addr_mod = (addr_sum >= DEPTH_L) ? addr_sum - DEPTH_L : addr_sum;
  end
  assign rd_addr = addr_mod[AW-1:0];

  vfd_ram #(
    .WIDTH (16),
    .DEPTH (CODEBOOK_DEPTH)
  ) u_codebook (
    .clk     (clk),
    .we      (cmd.ram_we),
    .wr_addr (red_r[AW-1:0]),
    .wr_data (coef_value_r),
    .rd_en   (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Operand of the issued term
  always_comb begin
    unique case (cmd.opsel)
      OP_HIST1: opnd = hist1_r;
      OP_HIST0: opnd = hist0_r;
      OP_SMP:   opnd = smp_r[cmd.opj];
      default:  opnd = '0;
    endcase
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_b_r <= cmd.issue;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    opnd_b_r <= opnd;
    prod_r   <= $signed(rd_data) * opnd_b_r;
    if (cmd.capture || cmd.fin) begin
      acc_r <= '0;
    end else if (vld_c_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Add the scaled nibble, floor-shift and saturate
  always_comb begin
    word    = cmd.idx[3] ? second_r : first_r;
    nib     = 4'(word >> {~cmd.idx[2:0], 2'b00});
    raw     = RAW_W'($signed(nib)) <<< scale_r;
    total   = acc_r + (ACC_W'(raw) <<< FRAC);
    shifted = total >>> FRAC;
    if (shifted > SAT_MAX) begin
      fin_sample = 16'sh7fff;
    end else if (shifted < SAT_MIN) begin
      fin_sample = -16'sh8000;
    end else begin
      fin_sample = shifted[15:0];
    end
  end

  // Store samples of the current half
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      smp_r[cmd.idx[2:0]] <= fin_sample;
    end
  end

  // History: clear on voice start, take last two outputs at half end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else if (cmd.capture && req_type == REQ_DECODE && start_voice) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else if (cmd.fin && cmd.hist_upd) begin
      hist0_r <= smp_r[6];
      hist1_r <= fin_sample;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_sample_r <= fin_sample;
      out_idx_r    <= cmd.idx;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample       = out_sample_r;
  assign out_ch.sample_index = out_idx_r;
  assign out_ch.last         = (out_idx_r == 4'd15);

  assign sts.red_ge   = red_ge;
  assign sts.out_free = !out_valid_r || out_ch.ready;
  assign sts.is_load  = (req_type_r == REQ_LOAD);

  `VFD_ASSERT_IMP(a_base_reduced, cmd.issue || cmd.ram_we, !red_ge)

endmodule

/* rtl/vadpcm_frame_decoder_core.sv */
// Top level of the VADPCM frame decoder: configuration registers, controller
// and datapath. Depends on vfd_pkg, vfd_if, vfd_ctrl and vfd_datapath.
//
//   Channel   Dir  Handshake          Word
//   in_ch     in   valid/ready        coefficient load or one 9-byte frame
//   out_ch    out  valid/ready        one decoded sample, index and last flag
//   cfg_*     in   write enable only  predictor count, order, codebook enable
//
// A frame is captured, then its base pred*order*8 is reduced modulo
// CODEBOOK_DEPTH one subtraction at a time; then each sample i of each half
// issues i+2 multiply-accumulate terms, one per cycle through the single
// codebook read port, drains the pipeline and finishes. With the codebook
// disabled a sample only finishes. A coefficient load is captured, its
// address is reduced the same way, and the coefficient is then written.
// Reset is synchronous; history and configuration return to reset values,
// the codebook is not cleared. A stalled output register holds the decoder in
// the finish step of the next sample.
module vadpcm_frame_decoder_core
  import vfd_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  vfd_in_if.sink      in_ch,
  vfd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  logic [4:0] pred_count_r;
  logic [3:0] cb_order_r;
  logic       cb_enable_r;
  logic       ctrl_ready;
  vfd_cmd_t   cmd;
  vfd_sts_t   sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_count_r <= 5'd1;
      cb_order_r   <= 4'd2;
      cb_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRED_COUNT: pred_count_r <= cfg_wdata;
        CFG_ORDER:      cb_order_r   <= cfg_wdata[3:0];
        CFG_ENABLE:     cb_enable_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = ctrl_ready;

  vfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (ctrl_ready),
    .cb_enable (cb_enable_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  vfd_datapath #(
    .CODEBOOK_DEPTH (CODEBOOK_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_type          (in_ch.req_type),
    .coef_index        (in_ch.coef_index),
    .coef_value        (in_ch.coef_value),
    .frame_header      (in_ch.frame_header),
    .frame_first_half  (in_ch.frame_first_half),
    .frame_second_half (in_ch.frame_second_half),
    .start_voice       (in_ch.start_voice),
    .pred_count        (pred_count_r),
    .cb_order          (cb_order_r),
    .cmd               (cmd),
    .sts               (sts),
    .out_ch            (out_ch)
  );

endmodule

/* dv/vadpcm_frame_decoder_core_test.sv */
// Self-checking bench for vadpcm_frame_decoder_core: random and directed frames and
// coefficient loads, checked sample by sample against an in-bench decoder.
// Depends on vfd_pkg, vfd_if and the RTL of the core.
module vadpcm_frame_decoder_core_test;
  import vfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB_DEPTH = 256;
  localparam int DRAIN_CYCLES = 24;
  localparam int FINAL_LIMIT = 20000;
  localparam int PRINT_LIMIT = 30;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One input word as the bench sees it
  typedef struct packed {
    logic               req_type;
    logic [7:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]         frame_header;
    logic [31:0]        first_half;
    logic [31:0]        second_half;
    logic               start_voice;
  } fd_word_t;

  // One decoded sample as it should leave the core
  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         idx;
    logic               last;
  } sample_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PRED_COUNT;
  logic [4:0] cfg_wdata = '0;

  vfd_in_if  in_ch();
  vfd_out_if out_ch();

  vadpcm_frame_decoder_core #(.CODEBOOK_DEPTH(CB_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state mirrored on the accepting side
  logic signed [15:0] codebook [CB_DEPTH];
  logic signed [15:0] hist_old = '0;
  logic signed [15:0] hist_new = '0;
  logic [4:0] cfg_pred_count = 5'd1;
  logic [3:0] cfg_order = 4'd2;
  logic       cfg_enable = 1'b0;

  // Stimulus bookkeeping
  fd_word_t     words_pending[$];
  sample_word_t samples_due[$];
  bit           gen_filled [CB_DEPTH];
  fd_word_t     on_bus;
  int words_queued = 0;
  int words_taken = 0;
  int frames_queued = 0;
  int loads_queued = 0;
  int samples_checked = 0;
  int mismatches = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  // Register settings of the random phases
  int ph_count [6] = '{4, 0, 2, 31, 16, 0};
  int ph_order [6] = '{2, 8, 3, 0, 1, 15};
  int ph_enable [6] = '{1, 1, 0, 1, 1, 1};

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT)
      $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pred_base(input logic [7:0] hdr);
    int pred;
    int ord;
    pred = hdr[3:0];
    if (cfg_pred_count != 0 && pred >= cfg_pred_count) pred = cfg_pred_count - 1;
    ord = (cfg_order == 0) ? 2 : cfg_order;
    return pred * ord * 8;
  endfunction

  function automatic longint coef_at(input int addr);
    return longint'(codebook[addr % CB_DEPTH]);
  endfunction

  // Apply one accepted word: store a coefficient or decode a frame into 16 samples
  function automatic void decode_word(input fd_word_t w);
    int base;
    int h;
    int i;
    int j;
    logic [31:0] half_bits;
    logic signed [3:0] nib;
    longint raw [8];
    longint acc;
    logic signed [15:0] smp [16];
    if (w.req_type == REQ_LOAD) begin
      codebook[w.coef_index] = w.coef_value;
    end else begin
      if (w.start_voice) begin
        hist_old = '0;
        hist_new = '0;
      end
      base = pred_base(w.frame_header);
      for (h = 0; h < 2; h++) begin
        half_bits = (h == 0) ? w.first_half : w.second_half;
        for (i = 0; i < 8; i++) begin
          nib = half_bits[31 - 4 * i -: 4];
          raw[i] = longint'(nib) <<< w.frame_header[7:4];
        end
        for (i = 0; i < 8; i++) begin
          acc = 0;
          if (cfg_enable) begin
            acc = coef_at(base + i) * longint'(hist_new)
                + coef_at(base + 8 + i) * longint'(hist_old);
            for (j = 0; j < i; j++)
              acc += coef_at(base + 8 + (i - 1 - j)) * longint'(smp[h * 8 + j]);
          end
          acc += raw[i] * 2048;
          acc = acc >>> 11;
          if (acc > 32767) smp[h * 8 + i] = 16'sh7FFF;
          else if (acc < -32768) smp[h * 8 + i] = 16'sh8000;
          else smp[h * 8 + i] = acc[15:0];
        end
        // history carries the last two outputs of the half
        hist_old = smp[h * 8 + 6];
        hist_new = smp[h * 8 + 7];
      end
      for (i = 0; i < 16; i++)
        samples_due.push_back('{sample: smp[i], idx: 4'(i), last: (i == 15)});
    end
  endfunction

  // Input driver: advance to the next pending word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_word(on_bus);
        words_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (words_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = words_pending.pop_front();
          in_ch.valid             <= 1'b1;
          in_ch.req_type          <= on_bus.req_type;
          in_ch.coef_index        <= on_bus.coef_index;
          in_ch.coef_value        <= on_bus.coef_value;
          in_ch.frame_header      <= on_bus.frame_header;
          in_ch.frame_first_half  <= on_bus.first_half;
          in_ch.frame_second_half <= on_bus.second_half;
          in_ch.start_voice       <= on_bus.start_voice;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each taken sample against the oldest expectation
  always @(posedge clk) begin
    sample_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (samples_due.size() == 0) begin
          report_mismatch($sformatf("sample %0d index %0d arrived with none expected",
                                    out_ch.sample, out_ch.sample_index));
        end else begin
          want = samples_due.pop_front();
          samples_checked++;
          if (out_ch.sample !== want.sample)
            report_mismatch($sformatf("sample at index %0d: got %0d, expected %0d",
                                      want.idx, out_ch.sample, want.sample));
          if (out_ch.sample_index !== want.idx)
            report_mismatch($sformatf("sample_index: got %0d, expected %0d",
                                      out_ch.sample_index, want.idx));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last at index %0d: got %b, expected %b",
                                      want.idx, out_ch.last, want.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  function automatic logic signed [15:0] rand_coef();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(8191)) - 4096);
  endfunction

  task automatic queue_load(input logic [7:0] addr, input logic signed [15:0] value);
    fd_word_t w;
    w = fd_word_t'({$urandom, $urandom, $urandom});
    w.req_type = REQ_LOAD;
    w.coef_index = addr;
    w.coef_value = value;
    gen_filled[addr] = 1'b1;
    words_pending.push_back(w);
    words_queued++;
    loads_queued++;
  endtask

  // Queue a frame, first loading any codebook entry it reads that is still unwritten
  task automatic queue_frame(input logic [7:0] hdr, input logic [31:0] a,
                             input logic [31:0] b, input logic sv);
    fd_word_t w;
    int base;
    int k;
    if (cfg_enable) begin
      base = pred_base(hdr);
      for (k = 0; k < 16; k++)
        if (!gen_filled[(base + k) % CB_DEPTH])
          queue_load(8'((base + k) % CB_DEPTH), rand_coef());
    end
    w = fd_word_t'({$urandom, $urandom, $urandom});
    w.req_type = REQ_DECODE;
    w.frame_header = hdr;
    w.first_half = a;
    w.second_half = b;
    w.start_voice = sv;
    words_pending.push_back(w);
    words_queued++;
    frames_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_PRED_COUNT: cfg_pred_count = data;
      CFG_ORDER:      cfg_order = data[3:0];
      CFG_ENABLE:     cfg_enable = data[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every word is taken and every sample seen, then let loads settle
  task automatic wait_idle();
    while (words_taken != words_queued || samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int phase_start;
    int phase_frames;
    int n;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.frame_header = '0;
    in_ch.frame_first_half = '0;
    in_ch.frame_second_half = '0;
    in_ch.start_voice = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 13;
    recv_gap_pct = 48;

    // plain scaled nibbles under reset settings: every nibble, both scale extremes
    queue_frame(8'h00, 32'h0123_4567, 32'h89AB_CDEF, 1'b1);
    queue_frame(8'hF0, 32'h7878_7878, 32'h8787_8787, 1'b0);
    queue_frame(8'hCF, 32'h7F80_08F7, 32'hE1D2_C3B4, 1'b0);
    // loads at the address and value extremes, frame fields ignored
    queue_load(8'h00, 16'sh8000);
    queue_load(8'hFF, 16'sh7FFF);
    queue_load(8'h01, 16'sh7FFF);
    wait_idle();

    // codebook on: clamped predictor, history carried from the plain frames
    write_reg(CFG_ENABLE, 5'h01);
    end_writes();
    queue_frame(8'h3A, $urandom, $urandom, 1'b0);
    queue_frame(8'h90, 32'h7777_7777, 32'h8888_8888, 1'b1);
    queue_frame(8'h05, $urandom, $urandom, 1'b0);

    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase == 2) begin
        send_gap_pct = 48;
        recv_gap_pct = 13;
      end else if (phase == 4) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      // upper write data bits beyond a register's width must be dropped
      write_reg(CFG_PRED_COUNT, 5'(ph_count[phase]));
      write_reg(CFG_ORDER, {1'($urandom), 4'(ph_order[phase])});
      write_reg(CFG_ENABLE, {4'($urandom), 1'(ph_enable[phase])});
      if (phase == 2) write_reg(CFG_UNUSED, 5'h1F);
      end_writes();

      phase_start = words_queued;
      phase_frames = 0;
      while (words_queued - phase_start < 26 || phase_frames < 6) begin
        if ($urandom_range(4) == 0) begin
          queue_load(8'($urandom), rand_coef());
        end else begin
          queue_frame(8'($urandom), $urandom, $urandom, ($urandom_range(3) == 0));
          phase_frames++;
        end
      end
    end

    // drain with a bound, then flag anything still owed
    for (n = 0; n < FINAL_LIMIT &&
         (words_taken != words_queued || samples_due.size() != 0); n++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (words_taken != words_queued)
      report_mismatch($sformatf("%0d words never accepted", words_queued - words_taken));
    if (samples_due.size() != 0)
      report_mismatch($sformatf("%0d samples never arrived", samples_due.size()));

    $display("Decoded %0d frames and applied %0d coefficient loads over 8 register settings;",
             frames_queued, loads_queued);
    $display("%0d samples compared, %0d mismatches.", samples_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Global watchdog
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/vfd_pkg.sv
rtl/vfd_if.sv
rtl/vfd_ram.sv
rtl/vfd_ctrl.sv
rtl/vfd_datapath.sv
rtl/vadpcm_frame_decoder_core.sv
dv/vadpcm_frame_decoder_core_test.sv
